// ===== src/apr_pkg.sv =====
// Shared types and constants for the aging page replacement unit.
// No dependencies; used by every module under src.
package apr_pkg;

  // Field widths fixed by the interface
  localparam int PageW     = 6;   // virtual page number; all 64 pages fit, no reduction needed
  localparam int CfgW      = 4;   // frames_in_use register
  localparam int OutIdxW   = 3;   // frame_index as reported
  localparam int CountW    = 16;  // fault counter

  // Internal frame index covers the full MAX_FRAMES range (1..64)
  localparam int FrameIdxW = 6;

  // Reference history: after the per-reference shift only the last seven
  // references still contribute a bit to any page's age.
  localparam int HistDepth = 7;
  localparam int AgeW      = HistDepth;

  localparam int                   MaxFramesDef = 8;
  localparam logic [CfgW-1:0]      CfgReset     = 4'd8;
  localparam logic [CountW-1:0]    CountMax     = 16'hFFFF;

  typedef logic [PageW-1:0]                 page_t;
  typedef logic [FrameIdxW-1:0]             fidx_t;
  typedef logic [HistDepth-1:0][PageW-1:0]  hist_pages_t;

  // Search record handed from cell to cell
  typedef struct packed {
    page_t            page;
    logic             hit;
    fidx_t            hit_idx;
    logic             empty;
    fidx_t            free_idx;
    logic             best_vld;
    logic [AgeW-1:0]  best_age;
    fidx_t            best_idx;
    page_t            best_page;
  } scan_t;

  // Frame table update broadcast to all cells
  typedef struct packed {
    logic   fill;
    logic   clr;
    fidx_t  idx;
    page_t  page;
  } frame_wr_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

// ===== src/apr_history.sv =====
// Shift line of the most recent page references; it stands in for the per-page ages.
// Depends on apr_pkg.
module apr_history (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic                 clr_i,
  input  apr_pkg::page_t       page_i,
  output apr_pkg::hist_pages_t pages_o,
  output logic [apr_pkg::HistDepth-1:0] vld_o
);

  apr_pkg::hist_pages_t                pages_q, pages_d;
  logic [apr_pkg::HistDepth-1:0]       vld_q, vld_d;

  // Advance the line on each reference, newest at tap 0; a clear drops all valid bits
  always_comb begin
    pages_d = pages_q;
    vld_d   = vld_q;
    if (push_i) begin
      pages_d = {pages_q[apr_pkg::HistDepth-2:0], page_i};
      vld_d   = {vld_q[apr_pkg::HistDepth-2:0], 1'b1};
    end
    if (clr_i) begin
      vld_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pages_q <= pages_d;
  end

  assign pages_o = pages_q;
  assign vld_o   = vld_q;

endmodule

// ===== src/apr_frame_cell.sv =====
// One physical frame: holds its page and occupancy, and updates the search
// record passing through it. Depends on apr_pkg.
module apr_frame_cell #(
  parameter int IDX = 0
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [apr_pkg::CfgW-1:0]      frames_in_use_i,
  input  apr_pkg::hist_pages_t          hist_pages_i,
  input  logic [apr_pkg::HistDepth-1:0] hist_vld_i,
  input  apr_pkg::frame_wr_t            wr_i,
  input  logic                          vld_i,
  input  apr_pkg::scan_t                rec_i,
  output logic                          vld_o,
  output apr_pkg::scan_t                rec_o
);

  localparam bit                        InRange = (IDX < (1 << apr_pkg::CfgW));
  localparam logic [apr_pkg::CfgW-1:0]  IdxCfg  = apr_pkg::CfgW'(IDX);
  localparam apr_pkg::fidx_t            IdxF    = apr_pkg::FrameIdxW'(IDX);

  logic                       occ_q, occ_d;
  apr_pkg::page_t             page_q, page_d;
  logic                       vld_q;
  apr_pkg::scan_t             rec_q, rec_d;
  logic                       active;
  logic [apr_pkg::AgeW-1:0]   age;

  // Frame 0 always takes part; a count above the chain enables every frame
  assign active = (IDX == 0) || (InRange && (IdxCfg < frames_in_use_i));

  // Rebuild the shifted age of this frame's page from the reference history
  always_comb begin
    for (int j = 0; j < apr_pkg::HistDepth; j++) begin
      age[apr_pkg::AgeW-1-j] = hist_vld_i[j] && (hist_pages_i[j] == page_q);
    end
  end

  // Update the passing search record; first match wins, ties keep the lower frame
  always_comb begin
    rec_d = rec_i;
    if (active && occ_q) begin
      if (!rec_i.hit && (page_q == rec_i.page)) begin
        rec_d.hit     = 1'b1;
        rec_d.hit_idx = IdxF;
      end
      if (!rec_i.best_vld || (age < rec_i.best_age)) begin
        rec_d.best_vld  = 1'b1;
        rec_d.best_age  = age;
        rec_d.best_idx  = IdxF;
        rec_d.best_page = page_q;
      end
    end
    if (active && !occ_q && !rec_i.empty) begin
      rec_d.empty    = 1'b1;
      rec_d.free_idx = IdxF;
    end
  end

  // Fill or empty the frame on commit
  always_comb begin
    occ_d  = occ_q;
    page_d = page_q;
    if (wr_i.fill && (wr_i.idx == IdxF)) begin
      occ_d  = 1'b1;
      page_d = wr_i.page;
    end
    if (wr_i.clr) begin
      occ_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
      vld_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      vld_q <= vld_i;
    end
  end

  // Hold the record until the next search arrives
  always_ff @(posedge clk_i) begin
    page_q <= page_d;
    if (vld_i) begin
      rec_q <= rec_d;
    end
  end

  assign vld_o = vld_q;
  assign rec_o = rec_q;

endmodule

// ===== src/aging_page_replacement_unit.sv =====
// Top level of the aging page replacement unit: control, counter, output register.
// Depends on apr_pkg, apr_history and apr_frame_cell.
//
//  Channel   | Handshake                          | Payload
//  ----------+------------------------------------+--------------------------------------
//  input     | in_valid_i / in_ready_o            | page_number_i, last_reference_i
//  result    | out_valid_o / out_ready_i          | was_fault_o, frame_index_o,
//            |                                    | evicted_valid_o, evicted_page_o,
//            |                                    | fault_count_o
//  config    | frames_in_use_we_i (no wait)       | frames_in_use_i
//
// A reference taken in idle is launched into the chain, passes the register in each
// frame cell, closes the scan in ST_DONE and commits into the output register.
// The input is ready again in the cycle the result appears, so a new reference is
// taken only once the previous one has committed.
// The result sits in an output register; a stalled result only delays the
// commit of the following reference. Reset empties all frames, clears the
// history and the fault count, and loads frames_in_use with 8.
module aging_page_replacement_unit #(
  parameter int MAX_FRAMES = apr_pkg::MaxFramesDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        frames_in_use_we_i,
  input  logic [apr_pkg::CfgW-1:0]    frames_in_use_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [apr_pkg::PageW-1:0]   page_number_i,
  input  logic                        last_reference_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic                        was_fault_o,
  output logic [apr_pkg::OutIdxW-1:0] frame_index_o,
  output logic                        evicted_valid_o,
  output logic [apr_pkg::PageW-1:0]   evicted_page_o,
  output logic [apr_pkg::CountW-1:0]  fault_count_o
);

  apr_pkg::state_e                 state_q, state_d;
  logic [apr_pkg::CfgW-1:0]        cfg_q;
  apr_pkg::page_t                  page_q;
  logic                            last_q;
  logic                            launch_q;
  logic [apr_pkg::CountW-1:0]      cnt_q, cnt_d, cnt_inc;
  logic [apr_pkg::CountW-1:0]      fault_cnt_q;
  logic                            out_vld_q, out_vld_d;
  logic                            fault_q;
  apr_pkg::fidx_t                  slot_q;
  logic                            ev_vld_q;
  apr_pkg::page_t                  ev_page_q;

  logic                            in_acc;
  logic                            commit;
  logic                            fault;
  logic                            evict;
  apr_pkg::fidx_t                  slot;

  logic [MAX_FRAMES:0]             chain_vld;
  apr_pkg::scan_t                  chain_rec [MAX_FRAMES+1];
  apr_pkg::scan_t                  launch_rec;
  apr_pkg::scan_t                  exit_rec;
  apr_pkg::frame_wr_t              wr;
  apr_pkg::hist_pages_t            hist_pages;
  logic [apr_pkg::HistDepth-1:0]   hist_vld;

  assign in_acc = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      apr_pkg::ST_IDLE: if (in_acc)               state_d = apr_pkg::ST_SCAN;
      apr_pkg::ST_SCAN: if (chain_vld[MAX_FRAMES]) state_d = apr_pkg::ST_DONE;
      apr_pkg::ST_DONE: if (commit)               state_d = apr_pkg::ST_IDLE;
      default:                                    state_d = apr_pkg::ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    in_ready_o = 1'b0;
    commit     = 1'b0;
    case (state_q)
      apr_pkg::ST_IDLE: in_ready_o = 1'b1;
      apr_pkg::ST_DONE: commit     = !out_vld_q || out_ready_i;
      default: begin
        in_ready_o = 1'b0;
        commit     = 1'b0;
      end
    endcase
  end

  // Launch a fresh search record into the first cell
  always_comb begin
    launch_rec      = '0;
    launch_rec.page = page_q;
  end

  assign chain_rec[0] = launch_rec;
  assign chain_vld[0] = launch_q;

  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    apr_frame_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i          (clk_i),
      .rst_ni         (rst_ni),
      .frames_in_use_i(cfg_q),
      .hist_pages_i   (hist_pages),
      .hist_vld_i     (hist_vld),
      .wr_i           (wr),
      .vld_i          (chain_vld[i]),
      .rec_i          (chain_rec[i]),
      .vld_o          (chain_vld[i+1]),
      .rec_o          (chain_rec[i+1])
    );
  end

  assign exit_rec = chain_rec[MAX_FRAMES];

  // Pick the frame: hit, else first empty frame, else oldest page
  always_comb begin
    fault = !exit_rec.hit;
    evict = !exit_rec.hit && !exit_rec.empty;
    if (exit_rec.hit) begin
      slot = exit_rec.hit_idx;
    end else if (exit_rec.empty) begin
      slot = exit_rec.free_idx;
    end else begin
      slot = exit_rec.best_idx;
    end
  end

  // Broadcast the frame update
  always_comb begin
    wr.fill = commit && fault;
    wr.clr  = commit && last_q;
    wr.idx  = slot;
    wr.page = page_q;
  end

  apr_history u_hist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (commit),
    .clr_i  (commit && last_q),
    .page_i (page_q),
    .pages_o(hist_pages),
    .vld_o  (hist_vld)
  );

  // Saturating fault count, cleared after the last reference of a string
  always_comb begin
    cnt_inc = cnt_q;
    if (fault && (cnt_q != apr_pkg::CountMax)) begin
      cnt_inc = cnt_q + apr_pkg::CountW'(1);
    end
    cnt_d = cnt_q;
    if (commit) begin
      cnt_d = last_q ? '0 : cnt_inc;
    end
  end

  // Output valid: set on commit, drop on transaction
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (commit) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= apr_pkg::ST_IDLE;
      cfg_q     <= apr_pkg::CfgReset;
      launch_q  <= 1'b0;
      cnt_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      launch_q  <= in_acc;
      cnt_q     <= cnt_d;
      out_vld_q <= out_vld_d;
      if (frames_in_use_we_i) begin
        cfg_q <= frames_in_use_i;
      end
    end
  end

  // Capture the reference and the result payload
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      page_q <= page_number_i;
      last_q <= last_reference_i;
    end
    if (commit) begin
      fault_q     <= fault;
      slot_q      <= slot;
      ev_vld_q    <= evict;
      ev_page_q   <= evict ? exit_rec.best_page : '0;
      fault_cnt_q <= cnt_inc;
    end
  end

  // Report the count including this reference, taken before any clear
  assign out_valid_o     = out_vld_q;
  assign was_fault_o     = fault_q;
  assign frame_index_o   = slot_q[apr_pkg::OutIdxW-1:0];
  assign evicted_valid_o = ev_vld_q;
  assign evicted_page_o  = ev_page_q;
  assign fault_count_o   = fault_cnt_q;

endmodule

// ===== src/apr_checker.sv =====
// Port-level checks for the aging page replacement unit, bound to the top level.
// Depends on apr_pkg for field widths.
module apr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        was_fault_o,
  input logic [apr_pkg::OutIdxW-1:0] frame_index_o,
  input logic                        evicted_valid_o,
  input logic [apr_pkg::PageW-1:0]   evicted_page_o,
  input logic [apr_pkg::CountW-1:0]  fault_count_o
);

  // A stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(frame_index_o)
      && $stable(evicted_page_o) && $stable(fault_count_o))
    else $error("result changed while stalled");

  // A hit never evicts
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && evicted_valid_o |-> was_fault_o)
    else $error("eviction reported on a hit");

  // A fault is always counted
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && was_fault_o |-> fault_count_o != '0)
    else $error("fault with zero fault count");

  // One reference at a time: busy right after a transaction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second reference taken while busy");

  // No result appears in the cycle after a reference is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind aging_page_replacement_unit apr_checker u_apr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_ready_o     (in_ready_o),
  .out_valid_o    (out_valid_o),
  .out_ready_i    (out_ready_i),
  .was_fault_o    (was_fault_o),
  .frame_index_o  (frame_index_o),
  .evicted_valid_o(evicted_valid_o),
  .evicted_page_o (evicted_page_o),
  .fault_count_o  (fault_count_o)
);
